FILE: hdl/sobel_edge_magnitude_rgb_assert.svh
// Assertion helpers; expect i_clk and i_rst_n in the using scope.
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_ASSERT_SVH

// same-cycle implication
`define SEM_AST_NOW(lbl, ant, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (cons)) \
        else $error("sobel assertion failed");

// next-cycle implication
`define SEM_AST_NXT(lbl, ant, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (cons)) \
        else $error("sobel assertion failed");

`endif

FILE: hdl/sem_pkg.sv
`default_nettype none
package sem_pkg;
    localparam int PIX_W      = 8;
    localparam int RGB_W      = 24;
    localparam int GRAD_W     = 11;
    localparam int SQ_W       = 20;
    localparam int SUM_W      = 21;
    localparam int SQRT_STEPS = 11;
    localparam int CNT_W      = 4;
    localparam int IR_W       = 17;
    localparam int H_W        = 16;
    localparam int WREG_W     = 11;
    localparam int CFG_W      = 16;
    localparam int CIDX_W     = 2;

    localparam logic [CIDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CIDX_W-1:0] REG_HEIGHT = 2'd1;

    localparam logic [WREG_W-1:0] WIDTH_RST  = 11'd1024;
    localparam logic [H_W-1:0]    HEIGHT_RST = 16'd1;

    typedef struct packed {
        logic accept;
        logic shift;
        logic grad;
        logic square;
        logic sqrt_init;
        logic sqrt_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic out_busy;
    } t_sts;
endpackage
`default_nettype wire

FILE: hdl/sem_pix_if.sv
`default_nettype none
interface sem_pix_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    modport source (output valid, mode, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, mode, red_in, green_in, blue_in, output ready);
endinterface
`default_nettype wire

FILE: hdl/sem_edge_if.sv
`default_nettype none
interface sem_edge_if;
    logic       valid;
    logic       ready;
    logic [7:0] edge_red;
    logic [7:0] edge_green;
    logic [7:0] edge_blue;
    logic       last_pixel;
    modport source (output valid, edge_red, edge_green, edge_blue, last_pixel, input ready);
    modport sink   (input valid, edge_red, edge_green, edge_blue, last_pixel, output ready);
endinterface
`default_nettype wire

FILE: hdl/sem_sqrt_lane.sv
`default_nettype none
module sem_sqrt_lane
    import sem_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_init,
    input  wire logic             i_step,
    input  wire logic [SQ_W-1:0]  i_sq_x,
    input  wire logic [SQ_W-1:0]  i_sq_y,
    output logic      [PIX_W-1:0] o_mag
);
    logic [SUM_W-1:0] r_s, r_r, r_bit;
    logic [SUM_W-1:0] trial;
    logic [11:0]      rounded;

    assign trial = r_r + r_bit;

    always_ff @(posedge i_clk) begin
        if (i_init) begin
            r_s   <= SUM_W'(i_sq_x) + SUM_W'(i_sq_y);
            r_r   <= '0;
            r_bit <= SUM_W'(1) << (SUM_W - 1);
        end else if (i_step) begin
            if (r_s >= trial) begin
                r_s <= r_s - trial;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    // r_s holds the remainder s - r^2 once done
    assign rounded = r_r[11:0] + ((r_s > r_r) ? 12'd1 : 12'd0);
    assign o_mag   = (rounded > 12'd255) ? 8'd255 : rounded[PIX_W-1:0];
endmodule
`default_nettype wire

FILE: hdl/sem_ctrl.sv
`default_nettype none
`include "sobel_edge_magnitude_rgb_assert.svh"
module sem_ctrl
    import sem_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire t_sts i_sts,
    output logic      o_in_ready,
    output t_cmd      o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_GRAD, S_SQUARE, S_INIT, S_SQRT, S_DONE
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE:   if (i_in_valid) r_state <= S_READ;
                S_READ:   r_state <= i_sts.emit ? S_GRAD : S_IDLE;
                S_GRAD:   r_state <= S_SQUARE;
                S_SQUARE: r_state <= S_INIT;
                S_INIT: begin
                    r_state <= S_SQRT;
                    r_cnt   <= '0;
                end
                S_SQRT: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(SQRT_STEPS - 1)) r_state <= S_DONE;
                end
                S_DONE:   if (!i_sts.out_busy) r_state <= S_IDLE;
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd           = '0;
        o_cmd.accept    = (r_state == S_IDLE) && i_in_valid;
        o_cmd.shift     = (r_state == S_READ);
        o_cmd.grad      = (r_state == S_GRAD);
        o_cmd.square    = (r_state == S_SQUARE);
        o_cmd.sqrt_init = (r_state == S_INIT);
        o_cmd.sqrt_step = (r_state == S_SQRT);
        o_cmd.load_out  = (r_state == S_DONE) && !i_sts.out_busy;
    end

    `SEM_AST_NXT(a_sqrt_len, r_state == S_SQRT && r_cnt == CNT_W'(SQRT_STEPS - 1), r_state == S_DONE)
    `SEM_AST_NXT(a_no_emit, r_state == S_READ && !i_sts.emit, r_state == S_IDLE)
    `SEM_AST_NOW(a_load_free, o_cmd.load_out, !i_sts.out_busy)
endmodule
`default_nettype wire

FILE: hdl/sem_datapath.sv
`default_nettype none
module sem_datapath
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    output t_sts                   o_sts,
    input  wire logic              i_cfg_we,
    input  wire logic [CIDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    input  wire logic              i_mode,
    input  wire logic [PIX_W-1:0]  i_red,
    input  wire logic [PIX_W-1:0]  i_green,
    input  wire logic [PIX_W-1:0]  i_blue,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output logic      [PIX_W-1:0]  o_red,
    output logic      [PIX_W-1:0]  o_green,
    output logic      [PIX_W-1:0]  o_blue,
    output logic                   o_last
);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic [WREG_W-1:0] r_width;
    logic [H_W-1:0]    r_height;
    logic [WW-1:0]     w;
    logic [H_W-1:0]    h;

    logic [RGB_W-1:0]  upper_mem  [MAX_WIDTH];
    logic [RGB_W-1:0]  middle_mem [MAX_WIDTH];
    logic [RGB_W-1:0]  r_up_q, r_mid_q, r_cur;
    logic [RGB_W-1:0]  r_win [3][3];   // [column][row], column 0 left

    logic [AW-1:0]     r_ic, r_oc;
    logic [IR_W-1:0]   r_ir;
    logic [H_W-1:0]    r_or;

    logic              restart, cfg_hit;
    logic              left_out, right_out, last_now;
    logic [31:0]       ic_inc, oc_inc;

    logic signed [GRAD_W-1:0] r_gx [3];
    logic signed [GRAD_W-1:0] r_gy [3];
    logic        [SQ_W-1:0]   r_sqx [3];
    logic        [SQ_W-1:0]   r_sqy [3];
    logic        [PIX_W-1:0]  mag [3];
    logic                     r_last;

    // effective geometry
    always_comb begin
        if (r_width == '0) begin
            w = WW'(1);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            w = WW'(MAX_WIDTH);
        end else begin
            w = WW'(r_width);
        end
        h = (r_height == '0) ? H_W'(1) : r_height;
    end

    assign cfg_hit = i_cfg_we && (i_cfg_idx == REG_WIDTH || i_cfg_idx == REG_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_WIDTH:  r_width  <= i_cfg_data[WREG_W-1:0];
                REG_HEIGHT: r_height <= i_cfg_data[H_W-1:0];
                default: ;
            endcase
        end
    end

    // line stores: read on accept, write back in the shift beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_up_q <= upper_mem[r_ic];
        if (i_cmd.shift)  upper_mem[r_ic] <= r_mid_q;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_mid_q <= middle_mem[r_ic];
        if (i_cmd.shift)  middle_mem[r_ic] <= r_cur;
    end

    // pixels below the image and flush beats enter as zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cur <= (!i_mode && (32'(r_ir) < 32'(h))) ? {i_red, i_green, i_blue} : '0;
        end
    end

    assign o_sts.emit = (r_ic != '0) ? (r_ir >= IR_W'(1)) : (r_ir >= IR_W'(2));

    assign ic_inc    = 32'(r_ic) + 32'd1;
    assign oc_inc    = 32'(r_oc) + 32'd1;
    assign left_out  = (r_oc == '0);
    assign right_out = (oc_inc >= 32'(w));
    assign last_now  = ((32'(r_or) + 32'd1) >= 32'(h)) && right_out;
    assign restart   = cfg_hit || (i_cmd.grad && last_now);

    // window and position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || restart) begin
            r_ic <= '0;
            r_ir <= '0;
            r_oc <= '0;
            r_or <= '0;
            for (int c = 0; c < 3; c++) begin
                for (int r = 0; r < 3; r++) r_win[c][r] <= '0;
            end
        end else begin
            if (i_cmd.shift) begin
                r_win[0] <= r_win[1];
                r_win[1] <= r_win[2];
                r_win[2][0] <= (r_ir < IR_W'(2)) ? '0 : r_up_q;
                r_win[2][1] <= (r_ir < IR_W'(1)) ? '0 : r_mid_q;
                r_win[2][2] <= r_cur;
                if (ic_inc >= 32'(w)) begin
                    r_ic <= '0;
                    if (r_ir != '1) r_ir <= r_ir + 1'b1;
                end else begin
                    r_ic <= AW'(ic_inc);
                end
            end
            if (i_cmd.grad) begin
                if (right_out) begin
                    r_oc <= '0;
                    r_or <= r_or + 1'b1;
                end else begin
                    r_oc <= AW'(oc_inc);
                end
            end
        end
    end

    // gradients, one lane per channel (red, green, blue)
    always_ff @(posedge i_clk) begin
        if (i_cmd.grad) begin
            r_last <= last_now;
            for (int k = 0; k < 3; k++) begin
                logic signed [GRAD_W-1:0] t [3][3];
                for (int c = 0; c < 3; c++) begin
                    for (int r = 0; r < 3; r++) begin
                        t[c][r] = ((c == 0 && left_out) || (c == 2 && right_out)) ? '0 :
                            $signed({3'b000, r_win[c][r][(2-k)*PIX_W +: PIX_W]});
                    end
                end
                r_gx[k] <= (t[2][0] + (t[2][1] <<< 1) + t[2][2])
                         - (t[0][0] + (t[0][1] <<< 1) + t[0][2]);
                r_gy[k] <= (t[0][2] + (t[1][2] <<< 1) + t[2][2])
                         - (t[0][0] + (t[1][0] <<< 1) + t[2][0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.square) begin
            for (int k = 0; k < 3; k++) begin
                logic signed [2*GRAD_W-1:0] px, py;
                px = r_gx[k] * r_gx[k];
                py = r_gy[k] * r_gy[k];
                r_sqx[k] <= px[SQ_W-1:0];
                r_sqy[k] <= py[SQ_W-1:0];
            end
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_lane
        sem_sqrt_lane u_lane (
            .i_clk  (i_clk),
            .i_init (i_cmd.sqrt_init),
            .i_step (i_cmd.sqrt_step),
            .i_sq_x (r_sqx[k]),
            .i_sq_y (r_sqy[k]),
            .o_mag  (mag[k])
        );
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_red   <= mag[0];
            o_green <= mag[1];
            o_blue  <= mag[2];
            o_last  <= r_last;
        end
    end

    assign o_sts.out_busy = o_out_valid && !i_out_ready;
endmodule
`default_nettype wire

FILE: hdl/sobel_edge_magnitude_rgb.sv
// A result leaves after the beat that completes its window passes read, gradient,
//   square, root setup, 11 root steps and the output load, which waits while the
//   output register is held. A new beat is accepted only when the last is done,
//   as set by the 11-step bit-serial square root and the single line-store port.
// Reset (synchronous, active low): width 1024, height 1, counters and window
//   cleared; line stores hold no reset value and are masked at the top rows.
`default_nettype none
module sobel_edge_magnitude_rgb
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    sem_pix_if.sink                i_pix,
    sem_edge_if.source             o_edge,
    input  wire logic              i_cfg_we,
    input  wire logic [CIDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]  i_cfg_data
);
    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    // sequencer: one beat in flight from accept to result
    sem_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .i_sts      (sts),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    assign i_pix.ready = in_ready;

    // line stores, 3x3 window, gradients, root lanes, output register
    sem_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_mode      (i_pix.mode),
        .i_red       (i_pix.red_in),
        .i_green     (i_pix.green_in),
        .i_blue      (i_pix.blue_in),
        .i_out_ready (o_edge.ready),
        .o_out_valid (o_edge.valid),
        .o_red       (o_edge.edge_red),
        .o_green     (o_edge.edge_green),
        .o_blue      (o_edge.edge_blue),
        .o_last      (o_edge.last_pixel)
    );
endmodule
`default_nettype wire

FILE: tb/sv/sobel_edge_magnitude_rgb_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module sobel_edge_magnitude_rgb_tb;
    import sem_pkg::*;

    localparam int MAX_W        = 1024;
    localparam int SETTLE_CYC   = 40;      // exceeds the result latency
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RAND_ITEMS   = 1400;
    localparam logic [CIDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic       mode;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_edge;

    // one row of the directed table: either a register write or a beat,
    // with an optional hand-worked result for that beat
    typedef struct packed {
        logic              is_cfg;
        logic [CIDX_W-1:0] idx;
        logic [CFG_W-1:0]  data;
        t_pix              px;
        logic              typed;
        t_edge             want;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic              cfg_we;
    logic [CIDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]  cfg_data;

    sem_pix_if  pix ();
    sem_edge_if edg ();

    sobel_edge_magnitude_rgb #(.MAX_WIDTH(MAX_W)) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix),
        .o_edge     (edg),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    // ---------------------------------------------------------------
    // Edge-magnitude predictor: its own line stores, window, counters
    // ---------------------------------------------------------------
    logic [23:0]    upper_mem  [MAX_W];
    logic [23:0]    middle_mem [MAX_W];
    logic [23:0]    win [9];           // index = column*3 + row, column 0 left
    int unsigned    in_col, in_row, out_col, out_row;
    logic [10:0]    img_w;
    logic [15:0]    img_h;

    t_edge          edge_q[$];         // results still owed by the block
    int             n_beats, n_edges, n_images, n_errors;
    bit             calm;              // no idling on either side

    function automatic int unsigned eff_w();
        if (img_w == 0) return 1;
        if (img_w > MAX_W) return MAX_W;
        return img_w;
    endfunction

    function automatic int unsigned eff_h();
        return (img_h == 0) ? 1 : img_h;
    endfunction

    function automatic void restart_image();
        for (int i = 0; i < 9; i++) win[i] = '0;
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    endfunction

    function automatic void apply_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
        if (idx == REG_WIDTH) begin
            img_w = val[10:0];
            restart_image();
        end else if (idx == REG_HEIGHT) begin
            img_h = val[15:0];
            restart_image();
        end
    endfunction

    // rounded root, clamped; anything past 255 saturates so stop early
    function automatic logic [7:0] round_root(int unsigned s);
        int unsigned n;
        n = 0;
        while (n <= 256 && (n + 1) * (n + 1) <= s) n++;
        if (s - n * n > n) n++;
        return (n > 255) ? 8'd255 : n[7:0];
    endfunction

    function automatic int win_tap(int c, int r, int sh, bit lo, bit ro);
        if (c == 0 && lo) return 0;
        if (c == 2 && ro) return 0;
        return int'((win[c*3 + r] >> sh) & 24'hFF);
    endfunction

    // advance the predictor by one accepted beat; returns 1 if a result is owed
    function automatic bit predict_edge(t_pix p);
        int unsigned w, h, ic, ir;
        logic [23:0] cur, u, m;
        bit emit, lo, ro, last;
        int gx, gy, sh;
        logic [7:0] mag [3];
        t_edge e;
        w = eff_w(); h = eff_h(); ic = in_col; ir = in_row;
        cur = '0;
        if (!p.mode && ir < h) cur = {p.red, p.green, p.blue};
        u = upper_mem[ic];
        m = middle_mem[ic];
        upper_mem[ic]  = m;
        middle_mem[ic] = cur;
        if (ir < 2) u = '0;
        if (ir < 1) m = '0;
        for (int i = 0; i < 6; i++) win[i] = win[i+3];
        win[6] = u; win[7] = m; win[8] = cur;
        emit = (ic >= 1) ? (ir >= 1) : (ir >= 2);
        ic++;
        if (ic >= w) begin
            ic = 0;
            if (ir < 17'h1FFFF) ir++;
        end
        in_col = ic; in_row = ir;
        if (!emit) return 1'b0;
        lo = (out_col == 0);
        ro = (out_col + 1 >= w);
        for (int k = 0; k < 3; k++) begin
            sh = 16 - 8*k;
            gx = (win_tap(2,0,sh,lo,ro) + 2*win_tap(2,1,sh,lo,ro) + win_tap(2,2,sh,lo,ro))
               - (win_tap(0,0,sh,lo,ro) + 2*win_tap(0,1,sh,lo,ro) + win_tap(0,2,sh,lo,ro));
            gy = (win_tap(0,2,sh,lo,ro) + 2*win_tap(1,2,sh,lo,ro) + win_tap(2,2,sh,lo,ro))
               - (win_tap(0,0,sh,lo,ro) + 2*win_tap(1,0,sh,lo,ro) + win_tap(2,0,sh,lo,ro));
            mag[k] = round_root(int'(gx*gx + gy*gy));
        end
        last = (out_row + 1 >= h) && ro;
        e.red = mag[0]; e.green = mag[1]; e.blue = mag[2]; e.last = last;
        edge_q.push_back(e);
        if (last) begin
            restart_image();
        end else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row = (out_row + 1) & 16'hFFFF;
            end
        end
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // Drivers (change on falling edge) and result checker (rising edge)
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        edg.ready <= calm || ($urandom_range(99) >= 25);
    end

    // Send one beat; valid from the previous beat stays high unless a random
    // idle gap, skipped while calm, drops it before the new beat is driven.
    task automatic send_beat(input t_pix p, output bit owed);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 25) begin
            pix.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix.valid    <= 1'b1;
        pix.mode     <= p.mode;
        pix.red_in   <= p.red;
        pix.green_in <= p.green;
        pix.blue_in  <= p.blue;
        @(posedge i_clk);
        while (!pix.ready) @(posedge i_clk);
        owed = predict_edge(p);
        n_beats++;
    endtask

    // drop valid, wait for every owed result, then let the pipe drain
    task automatic settle();
        @(negedge i_clk);
        pix.valid <= 1'b0;
        while (edge_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        apply_reg(idx, val);
        @(negedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && edg.valid && edg.ready) begin
            t_edge got, exp_e;
            got = '{edg.edge_red, edg.edge_green, edg.edge_blue, edg.last_pixel};
            if (edge_q.size() == 0) begin
                $display("%0t: unexpected result r=%h g=%h b=%h last=%b",
                         $time, got.red, got.green, got.blue, got.last);
                n_errors++;
            end else begin
                exp_e = edge_q.pop_front();
                if (got !== exp_e) begin
                    $display("%0t: mismatch expected r=%h g=%h b=%h last=%b, got r=%h g=%h b=%h last=%b",
                             $time, exp_e.red, exp_e.green, exp_e.blue, exp_e.last,
                             got.red, got.green, got.blue, got.last);
                    n_errors++;
                end
                n_edges++;
                if (got.last) n_images++;
            end
        end
    end

    // watchdog
    int unsigned cyc;
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic t_row cfg_row(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
        t_row r;
        r = '0; r.is_cfg = 1'b1; r.idx = idx; r.data = val;
        return r;
    endfunction

    function automatic t_row beat_row(logic md, logic [23:0] rgb);
        t_row r;
        r = '0; r.px = '{md, rgb[23:16], rgb[15:8], rgb[7:0]};
        return r;
    endfunction

    function automatic t_pix rand_pix(logic md);
        t_pix p;
        p.mode = md; p.red = $urandom_range(255);
        p.green = $urandom_range(255); p.blue = $urandom_range(255);
        return p;
    endfunction

    t_row dir_tab[$];
    t_edge lone_pixel;
    initial begin
        bit owed;
        int unsigned w, h, k;
        logic [CFG_W-1:0] rw, rh;

        i_rst_n = 1'b0; cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
        pix.valid = 1'b0; pix.mode = 1'b0;
        pix.red_in = '0; pix.green_in = '0; pix.blue_in = '0;
        edg.ready = 1'b0;
        calm = 1'b0; cyc = 0;
        n_beats = 0; n_edges = 0; n_images = 0; n_errors = 0;
        for (int i = 0; i < MAX_W; i++) begin
            upper_mem[i] = '0; middle_mem[i] = '0;
        end
        img_w = WIDTH_RST; img_h = HEIGHT_RST;
        restart_image();

        // a one-pixel image has no neighbours, so its magnitude is zero
        lone_pixel = '{8'd0, 8'd0, 8'd0, 1'b1};

        // 1x1 image, then width/height zero (both act as 1)
        dir_tab.push_back(cfg_row(REG_WIDTH, 16'd1));
        dir_tab.push_back(cfg_row(REG_HEIGHT, 16'd1));
        dir_tab.push_back(beat_row(1'b0, 24'hFFFFFF));
        dir_tab.push_back(beat_row(1'b1, 24'h000000));
        dir_tab.push_back(beat_row(1'b1, 24'h000000));
        dir_tab[$].typed = 1'b1; dir_tab[$].want = lone_pixel;
        dir_tab.push_back(cfg_row(REG_WIDTH, 16'd0));
        dir_tab.push_back(cfg_row(REG_HEIGHT, 16'd0));
        dir_tab.push_back(beat_row(1'b0, 24'h000000));
        dir_tab.push_back(beat_row(1'b0, 24'hFFFFFF));   // below image: zero
        dir_tab.push_back(beat_row(1'b1, 24'hFFFFFF));
        dir_tab[$].typed = 1'b1; dir_tab[$].want = lone_pixel;
        // unused index is ignored; register extremes; then a 3x2 image
        dir_tab.push_back(cfg_row(REG_UNUSED, 16'd5));
        dir_tab.push_back(cfg_row(REG_WIDTH, 16'd2047));
        dir_tab.push_back(cfg_row(REG_HEIGHT, 16'hFFFF));
        dir_tab.push_back(cfg_row(REG_WIDTH, 16'd3));
        dir_tab.push_back(cfg_row(REG_HEIGHT, 16'd2));
        dir_tab.push_back(beat_row(1'b0, 24'hFF0000));
        dir_tab.push_back(beat_row(1'b0, 24'h00FF00));
        dir_tab.push_back(beat_row(1'b0, 24'h0000FF));
        dir_tab.push_back(beat_row(1'b0, 24'hFFFFFF));
        dir_tab.push_back(beat_row(1'b1, 24'hFFFFFF));   // flush inside image
        dir_tab.push_back(beat_row(1'b0, 24'h808080));
        for (int i = 0; i < 4; i++) dir_tab.push_back(beat_row(1'b1, 24'h000000));

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (dir_tab[i]) begin
            if (dir_tab[i].is_cfg) begin
                settle();
                write_reg(dir_tab[i].idx, dir_tab[i].data);
            end else begin
                send_beat(dir_tab[i].px, owed);
                if (dir_tab[i].typed && owed) edge_q[$] = dir_tab[i].want;
            end
        end

        // widest row: first row only, so no line-store reads are unmasked
        settle();
        write_reg(REG_WIDTH, 16'd1024);
        write_reg(REG_HEIGHT, 16'd2);
        for (int i = 0; i < 300; i++) send_beat(rand_pix(1'b0), owed);
        settle();
        write_reg(REG_WIDTH, 16'd4);

        // random images: mostly whole frames with drain, some noise
        while (n_beats < RAND_ITEMS) begin
            calm = (n_beats >= 900 && n_beats < 1100);
            k = $urandom_range(99);
            if (k < 10) begin
                repeat ($urandom_range(1, 12)) send_beat(rand_pix($urandom_range(3) == 0), owed);
                settle();
                write_reg(REG_WIDTH, 16'($urandom_range(1, 8)));
            end else begin
                if ($urandom_range(99) < 70) begin
                    rw = ($urandom_range(9) == 0) ? 16'($urandom_range(9, 64))
                                                  : 16'($urandom_range(1, 8));
                    rh = 16'($urandom_range(1, 5));
                    settle();
                    write_reg(REG_WIDTH, rw);
                    write_reg(REG_HEIGHT, rh);
                end
                w = eff_w(); h = eff_h();
                if (h > 8) begin
                    // never-ending image: feed a few rows and abandon it
                    repeat (3 * w) send_beat(rand_pix(1'b0), owed);
                    settle();
                    write_reg(REG_HEIGHT, 16'd2);
                end else begin
                    repeat (w * h) send_beat(rand_pix($urandom_range(19) == 0), owed);
                    repeat (w + 1) send_beat(rand_pix($urandom_range(3) != 0), owed);
                end
            end
        end
        calm = 1'b0;

        settle();
        $display("Ran %0d beats, checked %0d edge results over %0d complete images,",
                 n_beats, n_edges, n_images);
        $display("widths 1 to 1024, with random stalls on both sides.");
        if (n_errors == 0 && edge_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
